// File: rtl/fdbu_pkg.sv
package fdbu_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 512;
	localparam int DepthBits = 24;
	localparam int StoreSize = MaxWidth * MaxHeight;
	localparam int StoreAw   = $clog2(StoreSize);
	// y * width + x reaches 511 * 2047 + 1023
	localparam int AddrW     = 21;
	localparam int WidthW    = 11;

	localparam logic [WidthW-1:0]    FRAME_WIDTH_RESET = 11'd640;
	localparam logic [DepthBits-1:0] DEPTH_FAR = {DepthBits{1'b1}};

	localparam logic [1:0] OUT_WRITTEN   = 2'd0;
	localparam logic [1:0] OUT_REJECTED  = 2'd1;
	localparam logic [1:0] OUT_DISCARDED = 2'd2;
	localparam logic [1:0] OUT_CLEARED   = 2'd3;

	localparam logic OP_SHADE = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [1:0] BLEND_OPAQUE   = 2'd0;
	localparam logic [1:0] BLEND_ADDITIVE = 2'd1;
	localparam logic [1:0] BLEND_MULTIPLY = 2'd2;

	// One classified fragment as it waits between front and back.
	typedef struct packed {
		logic                 opcode;
		logic                 in_store;
		logic [StoreAw-1:0]   index;
		logic [DepthBits-1:0] depth;
		logic [11:0]          light_red;
		logic [11:0]          light_green;
		logic [11:0]          light_blue;
		logic [7:0]           texel_red;
		logic [7:0]           texel_green;
		logic [7:0]           texel_blue;
		logic                 cutout_enable;
		logic [1:0]           blend_mode;
	} frag_t;

endpackage

// File: rtl/fdbu_ram.sv
module fdbu_ram #(
	parameter int W = 16,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/fdbu_fifo.sv
module fdbu_fifo import fdbu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  frag_t push_data,
	input  logic  pop,
	output frag_t head,
	output logic  full,
	output logic  empty
);

	frag_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: rtl/fdbu_front.sv
module fdbu_front import fdbu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [10:0]   cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [111:0]  s_tdata,
	input  logic          s_tuser,
	input  logic          queue_full,
	input  logic          clearing,
	output logic          push,
	output frag_t         push_data
);

	logic [WidthW-1:0] frame_width_q;
	logic [AddrW-1:0]  addr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RESET;
		end else if (cfg_valid) begin
			frame_width_q <= cfg_data;
		end
	end

	assign s_tready = !queue_full && !clearing;
	assign push     = s_tvalid && s_tready;

	// Row-major address; columns past the row width simply alias onward.
	assign addr = AddrW'(s_tdata[18:10]) * AddrW'(frame_width_q) + AddrW'(s_tdata[9:0]);

	always_comb begin
		push_data.opcode        = s_tuser;
		push_data.in_store      = (addr < AddrW'(StoreSize));
		push_data.index         = addr[StoreAw-1:0];
		push_data.depth         = s_tdata[42:19];
		push_data.light_red     = s_tdata[54:43];
		push_data.light_green   = s_tdata[66:55];
		push_data.light_blue    = s_tdata[78:67];
		push_data.texel_red     = s_tdata[86:79];
		push_data.texel_green   = s_tdata[94:87];
		push_data.texel_blue    = s_tdata[102:95];
		push_data.cutout_enable = s_tdata[103];
		push_data.blend_mode    = s_tdata[105:104];
	end

endmodule

// File: rtl/fdbu_back.sv
module fdbu_back import fdbu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  frag_t        head,
	input  logic         empty,
	output logic         pop,
	output logic         clearing,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,
	output logic [1:0]   m_tuser
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_TEST  = 2'd1;
	localparam logic [1:0] S_BLEND = 2'd2;

	function automatic logic [7:0] modulate(input logic [7:0] t, input logic [11:0] l);
		logic [19:0] p;
		p = 20'(t) * 20'(l);
		return (p[19:18] != 2'd0) ? 8'd255 : p[17:10];
	endfunction

	// v*255/31 truncated, by reciprocal 2^22/31 rounded up
	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [12:0] n;
		logic [30:0] p;
		n = (13'(v) << 8) - 13'(v);
		p = 31'(n) * 31'd135301;
		return p[29:22];
	endfunction

	function automatic logic [7:0] expand6(input logic [5:0] v);
		logic [13:0] n;
		logic [30:0] p;
		n = (14'(v) << 8) - 14'(v);
		p = 31'(n) * 31'd66577;
		return p[29:22];
	endfunction

	function automatic logic [7:0] inv_mul(input logic [7:0] d, input logic [7:0] c);
		logic [16:0] x;
		x = 17'(d) * 17'(8'd255 - c);
		x = x + (x >> 8) + 17'd1;
		return x[15:8];
	endfunction

	function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? 8'd255 : s[7:0];
	endfunction

	logic [1:0]         state_q;
	frag_t              item_q;
	logic               clr_active_q;
	logic [StoreAw-1:0] clr_idx_q;
	logic [1:0]         outcome_q;
	logic [7:0]         r_q, g_q, b_q, dr_q, dg_q, db_q;
	logic               out_valid_q;
	logic [1:0]         out_outcome_q;
	logic [15:0]        out_pixel_q;
	logic               out_dw_q;

	logic [DepthBits-1:0] rd_depth;
	logic [15:0]          rd_colour;
	logic                 nearer, black;
	logic [7:0]           br, bg, bb;
	logic [15:0]          pixel;
	logic                 finish;
	logic                 depth_we, colour_we;
	logic [StoreAw-1:0]   waddr;
	logic [DepthBits-1:0] depth_wdata;
	logic [15:0]          colour_wdata;
	logic                 blend_dw;

	assign clearing = clr_active_q;
	assign pop      = (state_q == S_IDLE) && !clr_active_q && !empty;
	assign finish   = (state_q == S_BLEND) && (!out_valid_q || m_tready);

	assign nearer = item_q.in_store && (item_q.depth < rd_depth);
	assign black  = (item_q.texel_red == 8'd0) && (item_q.texel_green == 8'd0)
		&& (item_q.texel_blue == 8'd0);

	always_comb begin
		unique case (item_q.blend_mode)
			BLEND_ADDITIVE: begin
				br = sat_add(r_q, dr_q);
				bg = sat_add(g_q, dg_q);
				bb = sat_add(b_q, db_q);
			end
			BLEND_MULTIPLY: begin
				br = inv_mul(dr_q, r_q);
				bg = inv_mul(dg_q, g_q);
				bb = inv_mul(db_q, b_q);
			end
			default: begin
				br = r_q;
				bg = g_q;
				bb = b_q;
			end
		endcase
		pixel = {br[7:3], bg[7:2], bb[7:3]};
	end

	assign blend_dw = (item_q.blend_mode != BLEND_ADDITIVE)
		&& (item_q.blend_mode != BLEND_MULTIPLY);

	always_comb begin
		if (clr_active_q) begin
			depth_we     = 1'b1;
			colour_we    = 1'b1;
			waddr        = clr_idx_q;
			depth_wdata  = DEPTH_FAR;
			colour_wdata = 16'd0;
		end else begin
			waddr        = item_q.index;
			colour_wdata = pixel;
			colour_we    = finish && (outcome_q == OUT_WRITTEN);
			if (outcome_q == OUT_CLEARED) begin
				depth_we    = finish && item_q.in_store;
				depth_wdata = DEPTH_FAR;
			end else begin
				depth_we    = finish && (outcome_q == OUT_WRITTEN) && blend_dw;
				depth_wdata = item_q.depth;
			end
		end
	end

	fdbu_ram #(.W(DepthBits), .D(StoreSize)) u_depth_ram (
		.clk   (clk),
		.we    (depth_we),
		.waddr (waddr),
		.wdata (depth_wdata),
		.raddr (head.index),
		.rdata (rd_depth)
	);

	fdbu_ram #(.W(16), .D(StoreSize)) u_colour_ram (
		.clk   (clk),
		.we    (colour_we),
		.waddr (waddr),
		.wdata (colour_wdata),
		.raddr (head.index),
		.rdata (rd_colour)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (state_q == S_TEST) begin
			r_q  <= modulate(item_q.texel_red, item_q.light_red);
			g_q  <= modulate(item_q.texel_green, item_q.light_green);
			b_q  <= modulate(item_q.texel_blue, item_q.light_blue);
			dr_q <= expand5(rd_colour[15:11]);
			dg_q <= expand6(rd_colour[10:5]);
			db_q <= expand5(rd_colour[4:0]);
		end
		if (finish) begin
			out_outcome_q <= outcome_q;
			out_pixel_q   <= (outcome_q == OUT_WRITTEN) ? pixel : 16'd0;
			out_dw_q      <= depth_we;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
			outcome_q    <= OUT_WRITTEN;
			out_valid_q  <= 1'b0;
		end else begin
			if (clr_active_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == {StoreAw{1'b1}}) begin
					clr_active_q <= 1'b0;
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_TEST;
					end
				end
				S_TEST: begin
					priority if (item_q.opcode == OP_CLEAR) begin
						outcome_q <= OUT_CLEARED;
					end else if (!nearer) begin
						outcome_q <= OUT_REJECTED;
					end else if (item_q.cutout_enable && black) begin
						outcome_q <= OUT_DISCARDED;
					end else begin
						outcome_q <= OUT_WRITTEN;
					end
					state_q <= S_BLEND;
				end
				S_BLEND: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_outcome_q;
	assign m_tdata  = {7'd0, out_dw_q, out_pixel_q};

endmodule

// File: rtl/fragment_depth_blend_unit.sv
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_valid/cfg_ready   frame_width, 11 bits
// s_axis    in         s_tvalid/s_tready     tdata fragment, tuser opcode
// m_axis    out        m_tvalid/m_tready     tdata pixel and depth flag, tuser outcome
//
// Each word passes through three back-end states: pop with store read, depth test
// and colour expansion, then blend with store write; the next word can pop in the
// cycle after. The stores have one read and one write port each.
// After reset the stores are swept to far depth and black, one entry a cycle,
// over all 524288 entries; s_tready stays low throughout.
// A two-entry queue sits between front and back. The blend cycle waits while the
// previous result is held, and can complete in the cycle that result is taken.
module fragment_depth_blend_unit import fdbu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [10:0]  cfg_data,   // frame_width
	input  logic         s_tvalid,
	output logic         s_tready,
	// pixel_x[9:0], pixel_y[18:10], frag_depth[42:19], light_red[54:43],
	// light_green[66:55], light_blue[78:67], texel_red[86:79],
	// texel_green[94:87], texel_blue[102:95], cutout_enable[103],
	// blend_mode[105:104], zero[111:106]
	input  logic [111:0] s_tdata,
	input  logic         s_tuser,    // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,    // pixel_value[15:0], depth_written[16], zero[23:17]
	output logic [1:0]   m_tuser     // outcome
);

	frag_t push_data;
	frag_t head;
	logic  push, pop, full, empty, clearing;

	// The front end turns the position into a store address and classifies it.
	fdbu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.queue_full (full),
		.clearing   (clearing),
		.push       (push),
		.push_data  (push_data)
	);

	fdbu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	// The back end owns both stores and does the read-modify-write.
	fdbu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// File: rtl/fdbu_checker.sv
module fdbu_checker import fdbu_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [23:0]  m_tdata,
	input logic [1:0]   m_tuser
);

	// A held result stays until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result dropped while stalled");

	// Rejected or discarded words never carry a pixel or depth update.
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == OUT_REJECTED || m_tuser == OUT_DISCARDED)
		|-> m_tdata[16:0] == 17'd0)
		else $error("pixel reported for a word that was not written");

	// A depth clear reports no colour.
	a_clear_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == OUT_CLEARED |-> m_tdata[15:0] == 16'd0)
		else $error("colour on a depth clear");

	// The input is closed when reset is released, as the store sweep begins.
	a_sweep: assert property (@(posedge clk)
		$rose(arst_n) |-> !s_tready)
		else $error("input opened during store sweep");

endmodule

bind fragment_depth_blend_unit fdbu_checker u_fdbu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
